### rtl/waam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package waam_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 12;
  // must be a power of two: the ring index wraps on its own and the magnitude mean is a shift
  localparam int WINDOW    = 8;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int TOT_W     = SAMPLE_W + IDX_W;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int MAGT_W    = MAG_W + IDX_W;
  localparam int THR_W     = 15;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3 << FRAC_BITS);

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WRAP_THRESHOLD = REG_IDX_W'(0);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef sample_t [WINDOW-1:0] window_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TOT_W-1:0]  tot;
    logic [MAGT_W-1:0]        mag;
    logic [CNT_W-1:0]         neg_cnt;
  } stat_t;

  function automatic mag_t mag_of(sample_t s);
    logic signed [MAG_W-1:0] w;
    w = MAG_W'(s);
    mag_of = (s < 0) ? mag_t'(-w) : mag_t'(w);
  endfunction

endpackage

`default_nettype wire

### rtl/wrap_aware_angle_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Moving average over the last 8 angle samples (signed Q4.12 radians), aware of
// the +/-pi wrap: when the window holds both signs and some sample's magnitude
// reaches wrap_threshold (APB byte address 0, reset 3.0), the output is the mean
// magnitude carrying the majority sign (positive on a tie) and tuser is set;
// otherwise it is the plain mean. Means truncate toward zero and the window
// starts out all zero. One word is taken every cycle; each result is registered
// in the running-total update stage and then in the result register. A stall on
// the output side holds the whole pipeline.

module wrap_aware_angle_moving_average
  import waam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [15:0]       s_tdata,   // [15:0] angle_sample

  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,   // [15:0] smoothed_angle
  output logic                   m_tuser,   // [0] wrap_mode_used

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic             en;
  logic [THR_W-1:0] threshold;
  window_t          window;
  stat_t            stat;
  sample_t          out_angle;
  logic             thr_sel;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign pready  = 1'b1;
  assign thr_sel = (paddr[ADDR_W-1:2] == REG_WRAP_THRESHOLD);
  assign prdata  = thr_sel ? DATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && thr_sel) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  waam_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_sample (sample_t'(s_tdata)),
    .window    (window),
    .stat      (stat)
  );

  waam_result u_result (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .stat      (stat),
    .window    (window),
    .threshold (threshold),
    .out_valid (m_tvalid),
    .out_angle (out_angle),
    .out_wrap  (m_tuser)
  );

  assign m_tdata = out_angle;

endmodule

`default_nettype wire

### rtl/waam_window.sv
`timescale 1ns / 1ps
`default_nettype none

module waam_window
  import waam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  sample_t   in_sample,
  output window_t   window,
  output stat_t     stat
);

  logic [IDX_W-1:0] pos;
  sample_t          old;
  stat_t            stat_next;

  assign old = window[pos];

  always_comb begin
    stat_next.valid   = in_valid;
    stat_next.tot     = stat.tot + TOT_W'(in_sample) - TOT_W'(old);
    stat_next.mag     = stat.mag + MAGT_W'(mag_of(in_sample)) - MAGT_W'(mag_of(old));
    stat_next.neg_cnt = stat.neg_cnt + CNT_W'(in_sample[SAMPLE_W-1])
                        - CNT_W'(old[SAMPLE_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      pos    <= '0;
      stat   <= '0;
    end else if (en) begin
      if (in_valid) begin
        window[pos] <= in_sample;
        pos         <= pos + IDX_W'(1);
        stat        <= stat_next;
      end else begin
        stat.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/waam_result.sv
`timescale 1ns / 1ps
`default_nettype none

module waam_result
  import waam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  stat_t                  stat,
  input  window_t                window,
  input  wire logic [THR_W-1:0]  threshold,
  output logic                   out_valid,
  output sample_t                out_angle,
  output logic                   out_wrap
);

  localparam logic signed [TOT_W-1:0] WINDOW_S = TOT_W'(WINDOW);
  localparam logic signed [TOT_W:0]   SAT_MAX  = (TOT_W+1)'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [TOT_W:0]   SAT_MIN  = -(TOT_W+1)'(2**(SAMPLE_W-1));

  logic                     any_large;
  logic                     wrap;
  logic signed [TOT_W-1:0]  plain_mean;
  logic [MAG_W-1:0]         mag_mean;
  logic signed [TOT_W:0]    pick;
  sample_t                  angle_next;

  always_comb begin
    any_large = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      if (mag_of(window[i]) >= MAG_W'(threshold)) any_large = 1'b1;
    end
  end

  assign wrap = (stat.neg_cnt != '0) && (stat.neg_cnt < CNT_W'(WINDOW)) && any_large;
  assign plain_mean = stat.tot / WINDOW_S;
  assign mag_mean   = MAG_W'(stat.mag >> IDX_W);

  always_comb begin
    if (!wrap) begin
      pick = (TOT_W+1)'(plain_mean);
    end else if (stat.neg_cnt > CNT_W'(WINDOW / 2)) begin
      pick = -(TOT_W+1)'(mag_mean);
    end else begin
      pick = (TOT_W+1)'(mag_mean);
    end
    priority if (pick > SAT_MAX) begin
      angle_next = SAMPLE_W'(SAT_MAX);
    end else if (pick < SAT_MIN) begin
      angle_next = SAMPLE_W'(SAT_MIN);
    end else begin
      angle_next = SAMPLE_W'(pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && stat.valid) begin
      out_angle <= angle_next;
      out_wrap  <= wrap;
    end
  end

endmodule

`default_nettype wire
